// ===== rtl/core/utf8_sanitizer_top_assert.svh =====
// Assertion macros for the UTF-8 sanitizer RTL.
`ifndef UTF8_SANITIZER_TOP_ASSERT_SVH
`define UTF8_SANITIZER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// Checked while out of reset
`define U8S_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checked at every edge, reset included
`define U8S_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define U8S_ASSERT(name, clk, rst_n, prop, msg)
`define U8S_ASSERT_ALWAYS(name, clk, prop, msg)
`endif

`endif

// ===== rtl/core/u8s_pkg.sv =====
// Shared types and constants of the UTF-8 sanitizer.
package u8s_pkg;

  // Most results one input item can cause: four sequence bytes and a terminator
  localparam int MAX_RESULTS   = 5;
  localparam int NUM_W         = 3;
  localparam int HELD_DEPTH    = 3;
  localparam int COUNT_W_DEF   = 32;
  localparam int CHAR_COUNT_W  = 32;

  localparam logic [7:0] REPL_RESET = 8'h3F;

  // Byte class masks and codes
  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_CODE  = 8'h80;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_CODE = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_CODE = 8'hE0;
  localparam logic [7:0] BAD_MASK   = 8'hF8;

  localparam logic [2:0] SEQ_NONE = 3'd0;
  localparam logic [2:0] SEQ_LEN2 = 3'd2;
  localparam logic [2:0] SEQ_LEN3 = 3'd3;
  localparam logic [2:0] SEQ_LEN4 = 3'd4;

  typedef enum logic [1:0] {
    CLS_ASCII = 2'd0,
    CLS_LEAD  = 2'd1,
    CLS_CONT  = 2'd2,
    CLS_BAD   = 2'd3
  } byte_class_t;

  typedef logic [MAX_RESULTS-1:0][7:0] byte_list_t;

  // Open multibyte sequence
  typedef struct packed {
    logic [2:0]                 len;
    logic [1:0]                 pos;
    logic [HELD_DEPTH-1:0][7:0] held;
  } seq_state_t;

  // Results caused by one item
  typedef struct packed {
    byte_list_t       bytes;
    logic [NUM_W-1:0] num;
    logic             term;
    logic [1:0]       inc;
  } step_res_t;

endpackage

// ===== rtl/core/u8s_step.sv =====
// Per-byte decode: classifies one byte and builds its result list and next sequence state.
module u8s_step
  import u8s_pkg::*;
(
  input  logic [7:0] data_byte,
  input  logic       end_of_string,
  input  logic [7:0] repl_byte,
  input  seq_state_t seq,
  output seq_state_t seq_nxt,
  output step_res_t  res
);

  byte_class_t      cls;
  logic [2:0]       lead_len;
  logic [2:0]       pos_p1;
  logic [NUM_W-1:0] n0;

  // Classify the byte
  always_comb begin
    if ((data_byte & CONT_MASK) == CONT_CODE) begin
      cls = CLS_CONT;
    end else if (!data_byte[7]) begin
      cls = CLS_ASCII;
    end else if ((data_byte & BAD_MASK) == BAD_MASK) begin
      cls = CLS_BAD;
    end else begin
      cls = CLS_LEAD;
    end
  end

  // Sequence length announced by a lead byte
  always_comb begin
    if ((data_byte & LEAD2_MASK) == LEAD2_CODE) begin
      lead_len = SEQ_LEN2;
    end else if ((data_byte & LEAD3_MASK) == LEAD3_CODE) begin
      lead_len = SEQ_LEN3;
    end else begin
      lead_len = SEQ_LEN4;
    end
  end

  assign pos_p1 = {1'b0, seq.pos} + 3'd1;

  // Result list and next state
  always_comb begin
    seq_nxt   = seq;
    res       = '0;
    n0        = '0;
    unique case (cls)
      CLS_CONT: begin
        if (seq.len == SEQ_NONE) begin
          // stray continuation
          res.bytes[0] = repl_byte;
          n0           = NUM_W'(1);
          res.inc      = 2'd1;
        end else if (pos_p1 >= seq.len - 3'd1) begin
          // sequence complete: held bytes then this one
          res.bytes[0] = seq.held[0];
          res.bytes[1] = (pos_p1 > 3'd1) ? seq.held[1] : data_byte;
          res.bytes[2] = (pos_p1 > 3'd2) ? seq.held[2] : data_byte;
          res.bytes[3] = data_byte;
          n0           = NUM_W'(pos_p1) + NUM_W'(1);
          res.inc      = 2'd1;
          seq_nxt.len  = SEQ_NONE;
          seq_nxt.pos  = '0;
        end else begin
          seq_nxt.held[pos_p1[1:0]] = data_byte;
          seq_nxt.pos               = pos_p1[1:0];
        end
      end
      CLS_ASCII: begin
        if (seq.len != SEQ_NONE) begin
          // broken sequence: replacement, then the ASCII byte
          res.bytes[0] = repl_byte;
          res.bytes[1] = data_byte;
          n0           = NUM_W'(2);
          res.inc      = 2'd2;
        end else begin
          res.bytes[0] = data_byte;
          n0           = NUM_W'(1);
          res.inc      = 2'd1;
        end
        seq_nxt.len = SEQ_NONE;
        seq_nxt.pos = '0;
      end
      CLS_LEAD: begin
        if (seq.len != SEQ_NONE) begin
          res.bytes[0] = repl_byte;
          n0           = NUM_W'(1);
          res.inc      = 2'd1;
        end
        seq_nxt.len     = lead_len;
        seq_nxt.pos     = '0;
        seq_nxt.held[0] = data_byte;
      end
      CLS_BAD: begin
        // dropped, sequence untouched
      end
    endcase

    // terminator goes after the byte results
    res.num = n0;
    if (end_of_string) begin
      for (int k = 0; k < MAX_RESULTS; k++) begin
        if (NUM_W'(k) == n0) begin
          res.bytes[k] = 8'h00;
        end
      end
      res.num     = n0 + NUM_W'(1);
      res.term    = 1'b1;
      seq_nxt.len = SEQ_NONE;
      seq_nxt.pos = '0;
    end
  end

endmodule

// ===== rtl/core/utf8_sanitizer_top.sv =====
// Top level of the UTF-8 sanitizer: sequence state, character counter and result queue.

// UTF-8 sanitizer. Takes one string byte per item and gives the sanitized bytes, one per
// result item, followed by a zero terminator (is_last high) carrying the character count
// of the string. Each byte is decoded in the cycle it is accepted and its results (up to
// five) go into a result shift register that drains one item per cycle while out_ready
// is high. A new input item is accepted when that register is empty or is handing over
// its last result, so the block takes one byte per cycle while out_ready is high and each
// byte causes at most one result; a byte causing more holds the input until its last one
// goes. Leads opening a sequence and dropped F8-FF bytes load nothing. The replacement
// byte is written through the cfg port, which is always ready; reset sets it to '?'.
`include "utf8_sanitizer_top_assert.svh"

module utf8_sanitizer_top
  import u8s_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_W_DEF
)
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [7:0]              in_data_byte,
  input  logic                    in_end_of_string,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [7:0]              out_byte,
  output logic                    out_is_last,
  output logic [CHAR_COUNT_W-1:0] out_char_count,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [7:0]              cfg_replacement_byte
);

  logic [7:0]              repl_r;
  seq_state_t              seq_r;
  seq_state_t              seq_nxt;
  step_res_t               res;
  logic [COUNT_WIDTH-1:0]  cnt_r;
  logic [COUNT_WIDTH-1:0]  cnt_sum;
  logic [CHAR_COUNT_W-1:0] cnt_sum32;
  byte_list_t              q_byte_r;
  byte_list_t              q_byte_nxt;
  logic [NUM_W-1:0]        q_num_r;
  logic [NUM_W-1:0]        q_num_nxt;
  logic                    q_term_r;
  logic                    q_term_nxt;
  logic [CHAR_COUNT_W-1:0] q_total_r;
  logic [CHAR_COUNT_W-1:0] q_total_nxt;
  logic                    in_acc;
  logic                    q_pop;
  logic                    eos_acc;
  logic                    seq_idle;
  logic                    seq_legal;

  // Replacement byte register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      repl_r <= REPL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      repl_r <= cfg_replacement_byte;
    end
  end

  // Byte decode
  u8s_step u_step (
    .data_byte     (in_data_byte),
    .end_of_string (in_end_of_string),
    .repl_byte     (repl_r),
    .seq           (seq_r),
    .seq_nxt       (seq_nxt),
    .res           (res)
  );

  // Handshake
  assign q_pop    = out_valid && out_ready;
  assign in_ready = (q_num_r == '0) || ((q_num_r == NUM_W'(1)) && out_ready);
  assign in_acc   = in_valid && in_ready;

  // Sequence state; held bytes need no reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r.len <= SEQ_NONE;
      seq_r.pos <= '0;
    end else if (in_acc) begin
      seq_r <= seq_nxt;
    end
  end

  // Character counter, wraps at COUNT_WIDTH bits
  assign cnt_sum = cnt_r + COUNT_WIDTH'(res.inc);

  generate
    if (COUNT_WIDTH >= CHAR_COUNT_W) begin : g_cnt_trunc
      assign cnt_sum32 = cnt_sum[CHAR_COUNT_W-1:0];
    end else begin : g_cnt_ext
      assign cnt_sum32 = {{(CHAR_COUNT_W-COUNT_WIDTH){1'b0}}, cnt_sum};
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (in_acc) begin
      cnt_r <= in_end_of_string ? '0 : cnt_sum;
    end
  end

  // Result queue: load a new list or shift one result out
  always_comb begin
    q_byte_nxt  = q_byte_r;
    q_num_nxt   = q_num_r;
    q_term_nxt  = q_term_r;
    q_total_nxt = q_total_r;
    if (in_acc && (res.num != '0)) begin
      q_byte_nxt  = res.bytes;
      q_num_nxt   = res.num;
      q_term_nxt  = res.term;
      q_total_nxt = cnt_sum32;
    end else if (q_pop) begin
      q_byte_nxt = byte_list_t'(q_byte_r >> 8);
      q_num_nxt  = q_num_r - NUM_W'(1);
      if (q_num_r == NUM_W'(1)) begin
        q_term_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_num_r  <= '0;
      q_term_r <= 1'b0;
    end else begin
      q_num_r  <= q_num_nxt;
      q_term_r <= q_term_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_byte_r  <= q_byte_nxt;
    q_total_r <= q_total_nxt;
  end

  // Output
  assign out_valid      = (q_num_r != '0);
  assign out_byte       = q_byte_r[0];
  assign out_is_last    = q_term_r && (q_num_r == NUM_W'(1));
  assign out_char_count = out_is_last ? q_total_r : '0;

  // Terms used by the checks
  assign eos_acc   = in_acc && in_end_of_string;
  assign seq_idle  = (seq_r.len == SEQ_NONE);
  assign seq_legal = (seq_r.len >= SEQ_LEN2) && (seq_r.len <= SEQ_LEN4) &&
                     (3'(seq_r.pos) <= seq_r.len - 3'd2);

  // Checks
  `U8S_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "queue not empty after reset")
  `U8S_ASSERT(a_idle_ready, clk, rst_n, !out_valid |-> in_ready, "empty queue blocks input")
  `U8S_ASSERT(a_eos_closes, clk, rst_n, eos_acc |=> (seq_idle && (cnt_r == '0)), "state open")
  `U8S_ASSERT(a_seq_pos, clk, rst_n, !seq_idle |-> seq_legal, "sequence position out of range")
  `U8S_ASSERT(a_term_zero, clk, rst_n, out_is_last |-> (out_byte == 8'h00), "terminator not zero")

endmodule
